// ===== sv/cda_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and calendar tables for the calendar date unit
// no dependencies; imported by cda_ctrl, cda_dp and calendar_date_arithmetic

package cda_pkg;

	// configuration limits
	localparam int MAX_DAY_COUNT = 65535;
	localparam int MAX_YEAR      = 9999;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 16;
	localparam int DIFF_W  = 23;
	localparam int ORD_W   = 22;

	// day ordinal of 31 dec of the last year, counted from 0001-01-01 as zero
	localparam logic [ORD_W-1:0] ORD_TOP = ORD_W'(365 * (MAX_YEAR - 1) + (MAX_YEAR - 1) / 4
		- (MAX_YEAR - 1) / 100 + (MAX_YEAR - 1) / 400 + 364);

	// cycle lengths in days
	localparam logic [ORD_W-1:0] DAYS_400Y = 22'd146097;
	localparam logic [ORD_W-1:0] DAYS_100Y = 22'd36524;
	localparam logic [ORD_W-1:0] DAYS_4Y   = 22'd1461;
	localparam logic [ORD_W-1:0] DAYS_1Y   = 22'd365;

	// divide by 100 as multiply by reciprocal and shift
	localparam int             RECIP_W   = 13;
	localparam int             PROD_W    = YEAR_W + RECIP_W;
	localparam int             RECIP_SH  = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_ADD  = 2'd1,
		ACT_SUB  = 2'd2,
		ACT_DIFF = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_INVALID = 2'd1,
		STS_RANGE   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		YS_400 = 2'd0,
		YS_100 = 2'd1,
		YS_4   = 2'd2,
		YS_1   = 2'd3
	} yr_stage_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_CUR1,
		ST_CUR2,
		ST_CUR3,
		ST_GIV1,
		ST_GIV2,
		ST_GIV3,
		ST_LOAD,
		ST_DIFF,
		ST_RANGE,
		ST_Y400,
		ST_Y100,
		ST_Y4,
		ST_Y1,
		ST_MON,
		ST_WRITE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic      accept;
		logic      sel_giv;
		logic      cap_cur;
		logic      cap_giv;
		logic      range_chk;
		logic      yr_step;
		yr_stage_t yr_stage;
		logic      mon_step;
		logic      load_fin;
		logic      diff_fin;
		logic      write_fin;
		logic      out_load;
	} cda_cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t act;
		logic    in_range;
		logic    yr_more;
		logic    mon_more;
		logic    out_free;
	} cda_sts_t;

	// month length in a common year, zero for a month that does not exist
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                        n = 5'd28;
			default:                                     n = 5'd0;
		endcase
		return n;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== sv/cda_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the calendar date unit: walks each item through its steps
// depends on cda_pkg; drives cda_dp through cda_cmd_t

module cda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cda_pkg::cda_sts_t sts,
	output cda_pkg::cda_cmd_t cmd
);
	import cda_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.yr_stage = YS_400;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_START;
				end
			end
			ST_START: begin
				state_nxt = (sts.act == ACT_LOAD) ? ST_GIV1 : ST_CUR1;
			end
			// ordinal of the stored date
			ST_CUR1: state_nxt = ST_CUR2;
			ST_CUR2: state_nxt = ST_CUR3;
			ST_CUR3: begin
				cmd.cap_cur = 1'b1;
				state_nxt   = (sts.act == ACT_DIFF) ? ST_GIV1 : ST_RANGE;
			end
			// ordinal and check of the given date
			ST_GIV1: begin
				cmd.sel_giv = 1'b1;
				state_nxt   = ST_GIV2;
			end
			ST_GIV2: state_nxt = ST_GIV3;
			ST_GIV3: begin
				cmd.cap_giv = 1'b1;
				state_nxt   = (sts.act == ACT_LOAD) ? ST_LOAD : ST_DIFF;
			end
			ST_LOAD: begin
				cmd.load_fin = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_DIFF: begin
				cmd.diff_fin = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_RANGE: begin
				cmd.range_chk = 1'b1;
				state_nxt     = sts.in_range ? ST_Y400 : ST_DONE;
			end
			// ordinal back to a date, one cycle chunk per beat of the loop
			ST_Y400: begin
				cmd.yr_stage = YS_400;
				cmd.yr_step  = sts.yr_more;
				if (!sts.yr_more) state_nxt = ST_Y100;
			end
			ST_Y100: begin
				cmd.yr_stage = YS_100;
				cmd.yr_step  = sts.yr_more;
				if (!sts.yr_more) state_nxt = ST_Y4;
			end
			ST_Y4: begin
				cmd.yr_stage = YS_4;
				cmd.yr_step  = sts.yr_more;
				if (!sts.yr_more) state_nxt = ST_Y1;
			end
			ST_Y1: begin
				cmd.yr_stage = YS_1;
				cmd.yr_step  = sts.yr_more;
				if (!sts.yr_more) state_nxt = ST_MON;
			end
			ST_MON: begin
				cmd.mon_step = sts.mon_more;
				if (!sts.mon_more) state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write_fin = 1'b1;
				state_nxt     = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// ===== sv/cda_dp.sv =====
`timescale 1ns / 1ps
// datapath of the calendar date unit: stored date, ordinal unit, year and
// month walk, result register; depends on cda_pkg, commanded by cda_ctrl

module cda_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cda_pkg::cda_cmd_t               cmd,
	output cda_pkg::cda_sts_t               sts,
	input  cda_pkg::action_t                in_action,
	input  logic [cda_pkg::DAY_W-1:0]       in_day,
	input  logic [cda_pkg::MONTH_W-1:0]     in_month,
	input  logic [cda_pkg::YEAR_W-1:0]      in_year,
	input  logic [cda_pkg::COUNT_W-1:0]     day_count,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [cda_pkg::DAY_W-1:0]       out_day,
	output logic [cda_pkg::MONTH_W-1:0]     out_month,
	output logic [cda_pkg::YEAR_W-1:0]      out_year,
	output logic signed [cda_pkg::DIFF_W-1:0] day_difference,
	output cda_pkg::status_t                status
);
	import cda_pkg::*;

	// latched item
	action_t            act_q;
	logic [DAY_W-1:0]   gday_q;
	logic [MONTH_W-1:0] gmon_q;
	logic [YEAR_W-1:0]  gyear_q;
	logic [COUNT_W-1:0] cnt_q;

	// stored date
	logic [DAY_W-1:0]   cur_day_q;
	logic [MONTH_W-1:0] cur_mon_q;
	logic [YEAR_W-1:0]  cur_year_q;

	// ordinal unit
	logic [DAY_W-1:0]   sel_d;
	logic [MONTH_W-1:0] sel_m;
	logic [YEAR_W-1:0]  sel_y;
	logic [YEAR_W-1:0]  sel_p;
	logic [YEAR_W+8:0]  p365_full;
	logic [PROD_W-1:0]  pprod_full;
	logic [PROD_W-1:0]  yprod_full;
	logic [DAY_W-1:0]   d_s1;
	logic [MONTH_W-1:0] m_s1;
	logic [YEAR_W-1:0]  y_s1;
	logic [YEAR_W-1:0]  p_s1;
	logic [ORD_W-1:0]   p365_s1;
	logic [PROD_W-1:0]  pprod_s1;
	logic [PROD_W-1:0]  yprod_s1;
	logic [7:0]         qp;
	logic [7:0]         qy;
	logic [14:0]        qy100;
	logic [YEAR_W-1:0]  rem100;
	logic               leap_c;
	logic [ORD_W-1:0]   base_c;
	logic [DAY_W-1:0]   d_s2;
	logic [MONTH_W-1:0] m_s2;
	logic [YEAR_W-1:0]  y_s2;
	logic               leap_s2;
	logic [ORD_W-1:0]   base_s2;
	logic [DAY_W-1:0]   mlen_s2;
	logic [ORD_W-1:0]   ord_c;
	logic               ok_c;
	logic [ORD_W-1:0]   cur_ord_q;
	logic [ORD_W-1:0]   giv_ord_q;
	logic               giv_ok_q;

	// range check
	logic [ORD_W:0]     nw;

	// year and month walk
	logic [ORD_W-1:0]   r_q;
	logic [YEAR_W-1:0]  yacc_q;
	logic [1:0]         n100_q;
	logic [4:0]         n4_q;
	logic [1:0]         n1_q;
	logic [MONTH_W-1:0] mm_q;
	logic [ORD_W-1:0]   chunk;
	logic [8:0]         chunk_yrs;
	logic               limit_hit;
	logic               leap_w;
	logic [DAY_W-1:0]   mlen_w;

	// result
	logic signed [DIFF_W-1:0] diff_q;
	status_t            sts_q;
	logic               out_valid_q;

	// item latch, day count saturated to the limit
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q   <= in_action;
			gday_q  <= in_day;
			gmon_q  <= in_month;
			gyear_q <= in_year;
			cnt_q   <= (day_count > COUNT_W'(MAX_DAY_COUNT)) ?
				COUNT_W'(MAX_DAY_COUNT) : day_count;
		end
	end

	// ordinal stage 1: year products
	assign sel_d      = cmd.sel_giv ? gday_q  : cur_day_q;
	assign sel_m      = cmd.sel_giv ? gmon_q  : cur_mon_q;
	assign sel_y      = cmd.sel_giv ? gyear_q : cur_year_q;
	assign sel_p      = sel_y - YEAR_W'(1);
	assign p365_full  = {9'd0, sel_p} * 23'd365;
	assign pprod_full = {{RECIP_W{1'b0}}, sel_p} * {{YEAR_W{1'b0}}, RECIP_100};
	assign yprod_full = {{RECIP_W{1'b0}}, sel_y} * {{YEAR_W{1'b0}}, RECIP_100};

	always_ff @(posedge clk) begin
		d_s1     <= sel_d;
		m_s1     <= sel_m;
		y_s1     <= sel_y;
		p_s1     <= sel_p;
		p365_s1  <= p365_full[ORD_W-1:0];
		pprod_s1 <= pprod_full;
		yprod_s1 <= yprod_full;
	end

	// ordinal stage 2: leap year and days before the year
	assign qp     = pprod_s1[RECIP_SH+7:RECIP_SH];
	assign qy     = yprod_s1[RECIP_SH+7:RECIP_SH];
	assign qy100  = {7'd0, qy} * 15'd100;
	assign rem100 = y_s1 - qy100[YEAR_W-1:0];
	assign leap_c = (y_s1[1:0] == 2'd0) && ((rem100 != '0) || (qy[1:0] == 2'd0));
	assign base_c = p365_s1 + ORD_W'(p_s1[YEAR_W-1:2]) - ORD_W'(qp) + ORD_W'(qp[7:2]);

	always_ff @(posedge clk) begin
		d_s2    <= d_s1;
		m_s2    <= m_s1;
		y_s2    <= y_s1;
		leap_s2 <= leap_c;
		base_s2 <= base_c;
	end

	// ordinal stage 3: month and day, date check
	assign mlen_s2 = month_len(m_s2) + DAY_W'(leap_s2 && (m_s2 == 4'd2));
	assign ord_c   = base_s2 + ORD_W'(cum_days(m_s2)) + ORD_W'(leap_s2 && (m_s2 > 4'd2))
		+ ORD_W'(d_s2) - ORD_W'(1);
	assign ok_c    = (y_s2 != '0) && (y_s2 <= YEAR_W'(MAX_YEAR)) && (m_s2 != '0)
		&& (m_s2 <= 4'd12) && (d_s2 != '0) && (d_s2 <= mlen_s2);

	always_ff @(posedge clk) begin
		if (cmd.cap_cur) begin
			cur_ord_q <= ord_c;
		end
		if (cmd.cap_giv) begin
			giv_ord_q <= ord_c;
			giv_ok_q  <= ok_c;
		end
	end

	// new ordinal for add and subtract
	assign nw = (act_q == ACT_ADD) ?
		({1'b0, cur_ord_q} + {{(ORD_W+1-COUNT_W){1'b0}}, cnt_q}) :
		({1'b0, cur_ord_q} - {{(ORD_W+1-COUNT_W){1'b0}}, cnt_q});

	// chunk for the current year stage
	always_comb begin
		case (cmd.yr_stage)
			YS_400: begin
				chunk     = DAYS_400Y;
				chunk_yrs = 9'd400;
				limit_hit = 1'b0;
			end
			YS_100: begin
				chunk     = DAYS_100Y;
				chunk_yrs = 9'd100;
				limit_hit = (n100_q == 2'd3);
			end
			YS_4: begin
				chunk     = DAYS_4Y;
				chunk_yrs = 9'd4;
				limit_hit = 1'b0;
			end
			default: begin
				chunk     = DAYS_1Y;
				chunk_yrs = 9'd1;
				limit_hit = (n1_q == 2'd3);
			end
		endcase
	end

	// leap year from the cycle counts, then month length in the walk
	assign leap_w = (n1_q == 2'd3) && ((n4_q != 5'd24) || (n100_q == 2'd3));
	assign mlen_w = month_len(mm_q) + DAY_W'(leap_w && (mm_q == 4'd2));

	// year and month walk registers
	always_ff @(posedge clk) begin
		if (cmd.range_chk) begin
			r_q    <= nw[ORD_W-1:0];
			yacc_q <= '0;
			n100_q <= '0;
			n4_q   <= '0;
			n1_q   <= '0;
			mm_q   <= 4'd1;
		end else if (cmd.yr_step) begin
			r_q    <= r_q - chunk;
			yacc_q <= yacc_q + YEAR_W'(chunk_yrs);
			case (cmd.yr_stage)
				YS_100:  n100_q <= n100_q + 2'd1;
				YS_4:    n4_q   <= n4_q + 5'd1;
				YS_1:    n1_q   <= n1_q + 2'd1;
				default: n100_q <= n100_q;
			endcase
		end else if (cmd.mon_step) begin
			r_q  <= r_q - ORD_W'(mlen_w);
			mm_q <= mm_q + 4'd1;
		end
	end

	// stored date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q  <= DAY_W'(1);
			cur_mon_q  <= MONTH_W'(1);
			cur_year_q <= YEAR_W'(1);
		end else if (cmd.load_fin) begin
			cur_day_q  <= giv_ok_q ? gday_q  : DAY_W'(1);
			cur_mon_q  <= giv_ok_q ? gmon_q  : MONTH_W'(1);
			cur_year_q <= giv_ok_q ? gyear_q : YEAR_W'(1);
		end else if (cmd.write_fin) begin
			cur_day_q  <= r_q[DAY_W-1:0] + DAY_W'(1);
			cur_mon_q  <= mm_q;
			cur_year_q <= yacc_q + YEAR_W'(1);
		end
	end

	// difference and status of the item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			diff_q <= '0;
			sts_q  <= STS_OK;
		end else if (cmd.load_fin) begin
			sts_q <= giv_ok_q ? STS_OK : STS_INVALID;
		end else if (cmd.diff_fin) begin
			if (giv_ok_q) begin
				diff_q <= $signed({1'b0, cur_ord_q}) - $signed({1'b0, giv_ord_q});
			end else begin
				sts_q <= STS_INVALID;
			end
		end else if (cmd.range_chk) begin
			if (!sts.in_range) sts_q <= STS_RANGE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_day        <= cur_day_q;
			out_month      <= cur_mon_q;
			out_year       <= cur_year_q;
			day_difference <= diff_q;
			status         <= sts_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	assign sts.act      = act_q;
	assign sts.in_range = !nw[ORD_W] && (nw[ORD_W-1:0] <= ORD_TOP);
	assign sts.yr_more  = (r_q >= chunk) && !limit_hit;
	assign sts.mon_more = (mm_q < 4'd12) && (r_q >= ORD_W'(mlen_w));
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ===== sv/calendar_date_arithmetic.sv =====
`timescale 1ns / 1ps
// calendar date unit: one stored gregorian date, load, add, subtract, difference
// a load or a difference takes the ordinal path only; an out-of-range add or subtract stops
//   after the range check; otherwise the result waits on the year and month walk
// one item at a time; next beat accepted the cycle after the result is loaded,
//   and later while a result waits on m_axis_tready
// reset: stored date becomes 0001-01-01, no result pending; depends on cda_pkg, cda_ctrl, cda_dp

module calendar_date_arithmetic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// in_day[4:0], in_month[8:5], in_year[22:9], day_count[38:23], zero[39]
	input  logic [39:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_day[4:0], out_month[8:5], out_year[22:9], day_difference[45:23], zero[47:46]
	output logic [47:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);
	import cda_pkg::*;

	cda_cmd_t               cmd;
	cda_sts_t               sts;
	logic [DAY_W-1:0]       o_day;
	logic [MONTH_W-1:0]     o_month;
	logic [YEAR_W-1:0]      o_year;
	logic signed [DIFF_W-1:0] o_diff;
	status_t                o_status;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cda_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_action      (action_t'(s_axis_tuser)),
		.in_day         (s_axis_tdata[4:0]),
		.in_month       (s_axis_tdata[8:5]),
		.in_year        (s_axis_tdata[22:9]),
		.day_count      (s_axis_tdata[38:23]),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_day        (o_day),
		.out_month      (o_month),
		.out_year       (o_year),
		.day_difference (o_diff),
		.status         (o_status)
	);

	// pack the result beat
	assign m_axis_tdata = {2'b00, o_diff, o_year, o_month, o_day};
	assign m_axis_tuser = o_status;

endmodule
